### rtl/ochs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ochs_pkg
// Shared types and constants for the cell height statistics block.
// ----------------------------------------------------------------------------
package ochs_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_GRID_SIDE_DEF = 64;
    localparam int MAX_RING_DEF      = 3;

    // Coordinate field width in the command word (covers a side of 256)
    localparam int COORD_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_RING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Arithmetic sizes
    localparam int           CNT_W     = 24;
    localparam int           MEAN_W    = 24;
    localparam int           M2_W      = 64;
    localparam int           SD_W      = 23;
    localparam int           DIFF_W    = 25;
    localparam logic [23:0]  COUNT_MAX = 24'hFF_FFFF;
    localparam logic [22:0]  STDEV_MAX = 23'h7F_FFFF;

    // Request codes on the input word
    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Operations passed to the back end
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_BAD   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         cell_x;
        logic [5:0]         cell_y;
        logic signed [15:0] height;
    } in_t;

    typedef struct packed {
        logic [23:0]        point_count;
        logic signed [23:0] mean_height;
        logic [22:0]        stdev_height;
        logic               bad_cell;
    } out_t;

    // Classified command: clipped box of cells to visit
    typedef struct packed {
        op_t                op;
        logic signed [15:0] height;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]         count;
        logic signed [MEAN_W-1:0] mean;
        logic [M2_W-1:0]          m2;
    } cell_t;

endpackage
`default_nettype wire

### rtl/ochs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ochs_front
// Holds configuration, accepts request words and turns them into commands
// with a clipped cell box.
// ----------------------------------------------------------------------------
module ochs_front
    import ochs_pkg::*;
#(
    parameter int MAX_GRID_SIDE = MAX_GRID_SIDE_DEF,
    parameter int MAX_RING      = MAX_RING_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_t                   s_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  q_full,
    input  wire logic                  back_clearing,
    output logic                       q_push,
    output cmd_t                       q_cmd
);

    localparam int CW = $clog2(MAX_GRID_SIDE);
    localparam int EW = ((CW > 6) ? CW : 6) + 2;

    logic [1:0]            ring_reg;
    logic [CFG_DATA_W-1:0] gw_reg;
    logic [CFG_DATA_W-1:0] gh_reg;

    logic [EW-1:0] eff_w, eff_h, r_cfg, r_use, cx_e, cy_e;
    logic [EW-1:0] x0, x1, y0, y1, xs, ys;
    logic          bad;
    req_t          req;

    // Write configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg <= 2'd0;
            gw_reg   <= 7'd64;
            gh_reg   <= 7'd64;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RING:   ring_reg <= cfg_wdata[1:0];
                CFG_WIDTH:  gw_reg   <= cfg_wdata;
                CFG_HEIGHT: gh_reg   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Clip sizes and radius to the built grid
    always_comb begin
        eff_w = (EW'(gw_reg) > EW'(MAX_GRID_SIDE)) ? EW'(MAX_GRID_SIDE) : EW'(gw_reg);
        eff_h = (EW'(gh_reg) > EW'(MAX_GRID_SIDE)) ? EW'(MAX_GRID_SIDE) : EW'(gh_reg);
        r_cfg = (EW'(ring_reg) > EW'(MAX_RING)) ? EW'(MAX_RING) : EW'(ring_reg);
        req   = req_t'(s_data.req_type);
        r_use = (req == REQ_ADD) ? r_cfg : '0;
        cx_e  = EW'(s_data.cell_x);
        cy_e  = EW'(s_data.cell_y);
        bad   = (cx_e >= eff_w) || (cy_e >= eff_h);
        x0    = (cx_e >= r_use) ? cx_e - r_use : '0;
        y0    = (cy_e >= r_use) ? cy_e - r_use : '0;
        xs    = cx_e + r_use;
        ys    = cy_e + r_use;
        x1    = (xs >= eff_w) ? eff_w - 1'b1 : xs;
        y1    = (ys >= eff_h) ? eff_h - 1'b1 : ys;
    end

    // Classify the word and push a command; drop unknown requests
    assign s_ready = !q_full && !back_clearing;
    assign q_push  = s_valid && s_ready && (req != REQ_NONE);

    always_comb begin
        q_cmd.height = s_data.height;
        q_cmd.x0     = COORD_W'(x0);
        q_cmd.x1     = COORD_W'(x1);
        q_cmd.y0     = COORD_W'(y0);
        q_cmd.y1     = COORD_W'(y1);
        case (req)
            REQ_CLEAR: q_cmd.op = OP_CLEAR;
            REQ_ADD:   q_cmd.op = bad ? OP_BAD : OP_ADD;
            default:   q_cmd.op = bad ? OP_BAD : OP_READ;
        endcase
    end

endmodule
`default_nettype wire

### rtl/ochs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ochs_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module ochs_fifo
    import ochs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t wdata,
    output logic      full,
    input  wire logic pop,
    output cmd_t      rdata,
    output logic      empty
);

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

### rtl/ochs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ochs_back
// Cell store and sequencer: Welford updates over the cell box, reads with
// shared restoring divider and bit-serial square root, clearing passes.
// ----------------------------------------------------------------------------
module ochs_back
    import ochs_pkg::*;
#(
    parameter int MAX_GRID_SIDE = MAX_GRID_SIDE_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_empty,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      clearing,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int CW    = $clog2(MAX_GRID_SIDE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_RD   = 11'b000_0000_0100,
        S_CALC = 11'b000_0000_1000,
        S_DIV  = 11'b000_0001_0000,
        S_MEAN = 11'b000_0010_0000,
        S_MUL  = 11'b000_0100_0000,
        S_WB   = 11'b000_1000_0000,
        S_NEXT = 11'b001_0000_0000,
        S_SQRT = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    cell_t                    mem [DEPTH];
    cell_t                    rd_cell_reg;
    logic [AW-1:0]            clr_idx_reg;
    cmd_t                     cmd_reg;
    logic [CW-1:0]            cx_reg, cy_reg;
    logic [DIFF_W-1:0]        da_abs_reg;
    logic                     da_neg_reg;
    logic signed [MEAN_W-1:0] mean_new_reg;
    logic [2*DIFF_W-1:0]      prod_reg;
    logic [DIFF_W-1:0]        div_rem_reg;
    logic [DIFF_W-1:0]        div_d_reg;
    logic [M2_W-1:0]          div_q_reg;
    logic [6:0]               cnt_reg;
    logic [M2_W-1:0]          sq_v_reg, sq_res_reg, sq_bit_reg;
    logic                     out_valid_reg;
    out_t                     out_reg;

    logic signed [MEAN_W-1:0] hq;
    logic signed [DIFF_W-1:0] da, db;
    logic [DIFF_W-1:0]        db_abs;
    logic signed [MEAN_W+1:0] mean_sum;
    logic [DIFF_W:0]          rem_sh;
    logic                     div_ge;
    logic [M2_W-1:0]          q_step;
    logic [M2_W-1:0]          sq_t;
    logic                     sq_ge;
    logic [M2_W:0]            m2_sum;
    logic                     last_x, last_y, out_free;
    logic [AW-1:0]            cell_addr;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    cell_t                    mem_wdata;
    out_t                     res;

    // Per-cell arithmetic
    always_comb begin
        hq       = {cmd_reg.height, 8'h00};
        da       = DIFF_W'(hq) - DIFF_W'(rd_cell_reg.mean);
        mean_sum = (MEAN_W+2)'(rd_cell_reg.mean)
                 + (da_neg_reg ? -$signed({1'b0, div_q_reg[DIFF_W-1:0]})
                               :  $signed({1'b0, div_q_reg[DIFF_W-1:0]}));
        db       = DIFF_W'(hq) - DIFF_W'(mean_new_reg);
        db_abs   = db[DIFF_W-1] ? DIFF_W'(-db) : DIFF_W'(db);
        m2_sum   = {1'b0, rd_cell_reg.m2} + (M2_W+1)'(prod_reg);
        rem_sh   = {div_rem_reg, div_q_reg[M2_W-1]};
        div_ge   = rem_sh >= {1'b0, div_d_reg};
        q_step   = {div_q_reg[M2_W-2:0], div_ge};
        sq_t     = sq_res_reg + sq_bit_reg;
        sq_ge    = sq_v_reg >= sq_t;
        last_x   = (cx_reg == cmd_reg.x1[CW-1:0]);
        last_y   = (cy_reg == cmd_reg.y1[CW-1:0]);
        out_free = !out_valid_reg || m_ready;
        cell_addr = {cy_reg, cx_reg};
    end

    // Assemble the result word
    always_comb begin
        res = '0;
        if (cmd_reg.op == OP_BAD) begin
            res.bad_cell = 1'b1;
        end else begin
            res.point_count = rd_cell_reg.count;
            res.mean_height = rd_cell_reg.mean;
            if (rd_cell_reg.count > 24'd1) begin
                res.stdev_height = (sq_res_reg > M2_W'(STDEV_MAX)) ? STDEV_MAX
                                                                  : sq_res_reg[SD_W-1:0];
            end
        end
    end

    // Sequence the work of one command
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (&clr_idx_reg) state_next = S_IDLE;
            S_IDLE: begin
                if (!q_empty) begin
                    case (q_cmd.op)
                        OP_CLEAR: state_next = S_CLR;
                        OP_BAD:   state_next = S_OUT;
                        default:  state_next = S_RD;
                    endcase
                end
            end
            S_RD:   state_next = S_CALC;
            S_CALC: begin
                if (cmd_reg.op == OP_ADD) begin
                    state_next = (rd_cell_reg.count == COUNT_MAX) ? S_NEXT : S_DIV;
                end else begin
                    state_next = (rd_cell_reg.count > 24'd1) ? S_DIV : S_OUT;
                end
            end
            S_DIV:  if (cnt_reg == 7'd1) state_next = (cmd_reg.op == OP_ADD) ? S_MEAN : S_SQRT;
            S_MEAN: state_next = S_MUL;
            S_MUL:  state_next = S_WB;
            S_WB:   state_next = S_NEXT;
            S_NEXT: state_next = (last_x && last_y) ? S_IDLE : S_RD;
            S_SQRT: if (cnt_reg == 7'd1) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign clearing = (state_reg == S_CLR);

    // Memory write port: clearing pass or write-back
    always_comb begin
        mem_we    = (state_reg == S_CLR) || (state_reg == S_WB);
        mem_waddr = (state_reg == S_CLR) ? clr_idx_reg : cell_addr;
        mem_wdata = '0;
        if (state_reg == S_WB) begin
            mem_wdata.count = rd_cell_reg.count + 1'b1;
            mem_wdata.mean  = mean_new_reg;
            mem_wdata.m2    = m2_sum[M2_W] ? {M2_W{1'b1}} : m2_sum[M2_W-1:0];
        end
    end

    // Cell store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_RD) begin
            rd_cell_reg <= mem[cell_addr];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLR) clr_idx_reg <= clr_idx_reg + 1'b1;
            if (state_reg == S_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                cmd_reg <= q_cmd;
                cx_reg  <= q_cmd.x0[CW-1:0];
                cy_reg  <= q_cmd.y0[CW-1:0];
            end
            S_CALC: begin
                div_rem_reg <= '0;
                da_neg_reg  <= da[DIFF_W-1];
                da_abs_reg  <= da[DIFF_W-1] ? DIFF_W'(-da) : DIFF_W'(da);
                if (cmd_reg.op == OP_ADD) begin
                    div_q_reg <= {(da[DIFF_W-1] ? DIFF_W'(-da) : DIFF_W'(da)),
                                  {(M2_W-DIFF_W){1'b0}}};
                    div_d_reg <= DIFF_W'(rd_cell_reg.count) + 1'b1;
                    cnt_reg   <= 7'(DIFF_W);
                end else begin
                    div_q_reg <= rd_cell_reg.m2;
                    div_d_reg <= DIFF_W'(rd_cell_reg.count) - 1'b1;
                    cnt_reg   <= 7'(M2_W);
                end
            end
            S_DIV: begin
                div_rem_reg <= div_ge ? DIFF_W'(rem_sh - {1'b0, div_d_reg})
                                      : rem_sh[DIFF_W-1:0];
                div_q_reg   <= q_step;
                if (cnt_reg == 7'd1) begin
                    sq_v_reg   <= q_step;
                    sq_res_reg <= '0;
                    sq_bit_reg <= M2_W'(1) << (M2_W - 2);
                    cnt_reg    <= 7'(M2_W / 2);
                end else begin
                    cnt_reg    <= cnt_reg - 1'b1;
                end
            end
            S_MEAN: mean_new_reg <= MEAN_W'(mean_sum);
            S_MUL:  prod_reg <= da_abs_reg * db_abs;
            S_NEXT: begin
                if (last_x) begin
                    cx_reg <= cmd_reg.x0[CW-1:0];
                    cy_reg <= cy_reg + 1'b1;
                end else begin
                    cx_reg <= cx_reg + 1'b1;
                end
            end
            S_SQRT: begin
                if (sq_ge) begin
                    sq_v_reg   <= sq_v_reg - sq_t;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg - 1'b1;
            end
            S_OUT:  if (out_free) out_reg <= res;
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Divider and root loops never run with an exhausted step count
    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV || state_reg == S_SQRT) |-> cnt_reg != 7'd0)
        else $error("step counter empty inside an iterative loop");

    // The cell walk stays inside the clipped box
    a_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD) |-> (cx_reg <= cmd_reg.x1[CW-1:0]
                                 && cy_reg <= cmd_reg.y1[CW-1:0]))
        else $error("cell walk left the box");

    // A saturated cell is never written back
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WB) |-> rd_cell_reg.count != COUNT_MAX)
        else $error("write-back to a saturated cell");

    // A result is only produced from an idle-dequeued command
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (cmd_reg.op == OP_BAD || cmd_reg.op == OP_READ))
        else $error("result for a command that gives none");

endmodule
`default_nettype wire

### rtl/overlapping_cell_height_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overlapping_cell_height_stats
// Grid of per-cell running mean and Welford deviation sums, updated by points
// over a ring of neighbor cells and read back as count, mean and stdev.
// ----------------------------------------------------------------------------
// Add: each updated cell runs a 25-step divider, a full cell is skipped, up to 49 cells.
// Read: a 64-step divider and a 32-step root give the result.
// Out-of-grid request: a result word with bad_cell set is given, with no cell access.
// Clear: the store is swept one entry a cycle.
// After reset the store is swept to zero, with s_ready held low.
// A two-entry command queue lets new words in while the sequencer works.
module overlapping_cell_height_stats
    import ochs_pkg::*;
#(
    parameter int MAX_GRID_SIDE = MAX_GRID_SIDE_DEF,
    parameter int MAX_RING      = MAX_RING_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_t                   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_t                       m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic q_push, q_pop, q_full, q_empty, clearing;
    cmd_t q_wcmd, q_rcmd;

    ochs_front #(
        .MAX_GRID_SIDE (MAX_GRID_SIDE),
        .MAX_RING      (MAX_RING)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .q_full        (q_full),
        .back_clearing (clearing),
        .q_push        (q_push),
        .q_cmd         (q_wcmd)
    );

    ochs_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wcmd),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rcmd),
        .empty   (q_empty)
    );

    ochs_back #(
        .MAX_GRID_SIDE (MAX_GRID_SIDE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_cmd    (q_rcmd),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

### test/tb_overlapping_cell_height_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overlapping_cell_height_stats
// Drives add, read and clear words over several grid and ring settings and
// checks every result word against a Welford grid predictor held in a class.
// ----------------------------------------------------------------------------
module tb_overlapping_cell_height_stats;
    import ochs_pkg::*;

    localparam int SIDE       = 64;
    localparam int RING_CAP   = 3;
    localparam int CELLS      = SIDE * SIDE;
    localparam int CYCLE_CAP  = 40000000;
    localparam int QUIET_WAIT = 16000;

    // Register index past the defined list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Grid statistics predictor and queue of expected result words
    class height_grid_board;
        bit [23:0]   cnt[CELLS];
        longint      avg[CELLS];
        bit [63:0]   sq_dev[CELLS];
        int unsigned ring, width, height;
        out_t        expected_q[$];
        int          mismatches;
        int          results_seen;

        function void clear_all();
            foreach (cnt[i]) begin
                cnt[i] = '0;
                avg[i] = 0;
                sq_dev[i] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_RING) ring = val & 3;
            else if (idx == CFG_WIDTH) width = val;
            else if (idx == CFG_HEIGHT) height = val;
        endfunction

        function int unsigned eff_w();
            return (width < SIDE) ? width : SIDE;
        endfunction

        function int unsigned eff_h();
            return (height < SIDE) ? height : SIDE;
        endfunction

        function bit [63:0] int_sqrt(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // Welford update of one cell; frozen once the count saturates
        function void fold_point(int idx, longint hq);
            longint    n, m, da, db;
            bit [63:0] ada, adb, prod;
            bit [64:0] sum;
            if (cnt[idx] == COUNT_MAX) return;
            n = longint'(cnt[idx]) + 1;
            m = avg[idx];
            da = hq - m;
            m = m + da / n;
            db = hq - m;
            ada = (da < 0) ? -da : da;
            adb = (db < 0) ? -db : db;
            prod = ada * adb;
            sum = {1'b0, sq_dev[idx]} + {1'b0, prod};
            sq_dev[idx] = sum[64] ? '1 : sum[63:0];
            avg[idx] = m;
            cnt[idx] = n[23:0];
        endfunction

        function void note_input(in_t w);
            int unsigned wd, ht;
            int          r, idx;
            out_t        res;
            bit [63:0]   sd;
            longint      hq;
            wd = eff_w();
            ht = eff_h();
            res = '0;
            if (w.req_type == REQ_CLEAR) begin
                clear_all();
                return;
            end
            if (w.req_type == REQ_NONE) return;
            if (w.cell_x >= wd || w.cell_y >= ht) begin
                res.bad_cell = 1'b1;
                expected_q.insert(expected_q.size(), res);
                return;
            end
            if (w.req_type == REQ_ADD) begin
                r = (ring < RING_CAP) ? ring : RING_CAP;
                hq = longint'(w.height) * 256;
                for (int y = int'(w.cell_y) - r; y <= int'(w.cell_y) + r; y++) begin
                    if (y < 0 || y >= int'(ht)) continue;
                    for (int x = int'(w.cell_x) - r; x <= int'(w.cell_x) + r; x++) begin
                        if (x < 0 || x >= int'(wd)) continue;
                        fold_point(y * SIDE + x, hq);
                    end
                end
                return;
            end
            // Read: sample deviation from M2 / (count - 1)
            idx = int'(w.cell_y) * SIDE + int'(w.cell_x);
            sd = 0;
            if (cnt[idx] > 1) begin
                sd = int_sqrt(sq_dev[idx] / (64'(cnt[idx]) - 1));
                if (sd > 64'(STDEV_MAX)) sd = 64'(STDEV_MAX);
            end
            res.point_count = cnt[idx];
            res.mean_height = avg[idx][23:0];
            res.stdev_height = sd[22:0];
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(out_t got);
            out_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: count %0d mean %0d sd %0d bad %0b",
                             got.point_count, got.mean_height, got.stdev_height,
                             got.bad_cell);
                return;
            end
            want = expected_q.pop_front();
            if (got.point_count !== want.point_count || got.mean_height !== want.mean_height
                || got.stdev_height !== want.stdev_height || got.bad_cell !== want.bad_cell) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp cnt/mean/sd/bad %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                             want.point_count, want.mean_height, want.stdev_height,
                             want.bad_cell, got.point_count, got.mean_height,
                             got.stdev_height, got.bad_cell);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    height_grid_board board;
    int               idle_pct;
    int               hold_req;
    int               hold_done;
    int               cycles;
    int               adds_sent, reads_sent, clears_sent;

    overlapping_cell_height_stats u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("overlapping_cell_height_stats test failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        int stall_left;
        if (hold_req != hold_done) begin
            hold_done = hold_req;
            stall_left = 3000;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Check each accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    task automatic send_word(input in_t w);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        board.note_input(w);
        case (w.req_type)
            REQ_ADD:   adds_sent++;
            REQ_READ:  reads_sent++;
            REQ_CLEAR: clears_sent++;
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(idx, val[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop valid, wait for all results, then let silent work finish
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (QUIET_WAIT) @(posedge aclk);
    endtask

    task automatic set_grid(input int ring, input int wd, input int ht);
        settle();
        write_reg(CFG_RING, ring);
        write_reg(CFG_WIDTH, wd);
        write_reg(CFG_HEIGHT, ht);
    endtask

    function automatic in_t make_word(input logic [1:0] req, input int x, input int y,
                                      input int h);
        in_t w;
        w.req_type = req;
        w.cell_x = x[5:0];
        w.cell_y = y[5:0];
        w.height = h[15:0];
        return w;
    endfunction

    // Coordinate mostly inside a small corner of the grid, so reads hit data
    function automatic int pick_coord(input int unsigned lim);
        if (lim > 0 && $urandom_range(99) < 85)
            return $urandom_range((lim < 8 ? lim : 8) - 1);
        return $urandom_range(63);
    endfunction

    task automatic random_phase(input int n);
        int          sel;
        logic [1:0]  req;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(999);
            if (sel < 8) req = REQ_CLEAR;
            else if (sel < 25) req = REQ_NONE;
            else if (sel < 580) req = REQ_ADD;
            else req = REQ_READ;
            send_word(make_word(req, pick_coord(board.eff_w()), pick_coord(board.eff_h()),
                                $urandom_range(65535)));
        end
    endtask

    initial begin
        board = new();
        board.ring = 0;
        board.width = SIDE;
        board.height = SIDE;
        board.clear_all();
        idle_pct = 15;
        hold_req = 0;
        hold_done = 0;
        cycles = 0;
        adds_sent = 0;
        reads_sent = 0;
        clears_sent = 0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RING;
        cfg_wdata = '0;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty reads, height extremes, ignored request, clear
        send_word(make_word(REQ_READ, 0, 0, 0));
        send_word(make_word(REQ_READ, 63, 63, 0));
        send_word(make_word(REQ_ADD, 0, 0, 32767));
        send_word(make_word(REQ_READ, 0, 0, 0));
        send_word(make_word(REQ_ADD, 0, 0, -32768));
        send_word(make_word(REQ_ADD, 0, 0, 0));
        send_word(make_word(REQ_READ, 0, 0, 0));
        send_word(make_word(REQ_ADD, 63, 63, -1));
        send_word(make_word(REQ_NONE, 63, 63, 21845));
        send_word(make_word(REQ_READ, 63, 63, 0));
        send_word(make_word(REQ_CLEAR, 0, 0, 0));
        send_word(make_word(REQ_READ, 0, 0, 0));

        // Directed: clipped ring at the corners, out-of-grid add and read
        set_grid(2, 5, 4);
        write_reg(CFG_SPARE, 127);
        send_word(make_word(REQ_ADD, 0, 0, 1000));
        send_word(make_word(REQ_ADD, 4, 3, -1000));
        send_word(make_word(REQ_ADD, 5, 0, 7));
        send_word(make_word(REQ_READ, 1, 1, 0));
        send_word(make_word(REQ_READ, 2, 2, 0));
        send_word(make_word(REQ_READ, 0, 4, 0));
        send_word(make_word(REQ_READ, 63, 63, 0));
        set_grid(1, 0, 7);
        send_word(make_word(REQ_ADD, 0, 0, 5));
        send_word(make_word(REQ_READ, 0, 0, 0));

        // Random phases over several settings
        set_grid(1, 64, 64);
        random_phase(350);
        set_grid(0, 3, 3);
        random_phase(250);
        set_grid(2, 100, 127);
        idle_pct = 0;
        random_phase(300);
        idle_pct = 15;
        set_grid(3, 9, 9);
        random_phase(120);
        set_grid(1, 1, 64);
        random_phase(200);
        set_grid(0, 0, 5);
        random_phase(80);
        set_grid(2, 16, 12);
        hold_req = hold_req + 1;
        random_phase(450);
        settle();

        $display("covered %0d adds, %0d reads, %0d clears; %0d result words checked",
                 adds_sent, reads_sent, clears_sent, board.results_seen);
        if (board.mismatches == 0 && board.expected_q.size() == 0) begin
            $display("overlapping_cell_height_stats test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", board.mismatches,
                     board.expected_q.size());
            $display("overlapping_cell_height_stats test failed");
        end
        $finish;
    end
endmodule
